[rtl/core/bc1_bc3_texel_block_decoder_macros.svh]
// ----------------------------------------------------------------------------
// bc1/bc3 texel block decoder assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BC1_BC3_TEXEL_BLOCK_DECODER_MACROS_SVH
`define BC1_BC3_TEXEL_BLOCK_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BCD_ASSERT_IMP(lbl, ante, cons, msg)
`define BCD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/bc13_pkg.sv]
// ----------------------------------------------------------------------------
// bc13_pkg
// shared types and constant-divide helpers of the bc1/bc3 texel decoder
// ----------------------------------------------------------------------------
package bc13_pkg;

  localparam int NUM_W   = 11;  // widest numerator: 7 * 255
  localparam int RECIP_W = 13;
  localparam int PROD_W  = NUM_W + RECIP_W;

  typedef enum logic [2:0] {
    DIV_PASS,
    DIV_BY2,
    DIV_BY3,
    DIV_BY5,
    DIV_BY7
  } div_op_t;

  // load enables of the multiply and output stages
  typedef struct packed {
    logic ld_mul;
    logic ld_out;
  } pipe_ctl_t;

  // scaled reciprocal, exact floor for the numerator ranges in use
  function automatic logic [RECIP_W-1:0] div_recip(input div_op_t op);
    logic [RECIP_W-1:0] r;
    case (op)
      DIV_BY3: r = RECIP_W'(683);
      DIV_BY5: r = RECIP_W'(6554);
      DIV_BY7: r = RECIP_W'(4682);
      default: r = RECIP_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic [3:0] div_shift(input div_op_t op);
    logic [3:0] s;
    case (op)
      DIV_BY2: s = 4'd1;
      DIV_BY3: s = 4'd11;
      DIV_BY5: s = 4'd15;
      DIV_BY7: s = 4'd15;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/bc13_chan_div.sv]
// ----------------------------------------------------------------------------
// bc13_chan_div
// two-stage divide by a small constant: reciprocal multiply, then shift
// ----------------------------------------------------------------------------
module bc13_chan_div (
  input  logic                             clk,
  input  bc13_pkg::pipe_ctl_t              ctl,
  input  logic [bc13_pkg::NUM_W-1:0]       num,
  input  bc13_pkg::div_op_t                op,
  output logic [7:0]                       result
);
  import bc13_pkg::*;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  div_op_t           op_r;
  logic [7:0]        res_r, res_nxt;
  logic [PROD_W-1:0] shifted;

  always_comb begin
    prod_nxt = {{RECIP_W{1'b0}}, num} * {{NUM_W{1'b0}}, div_recip(op)};
    shifted  = prod_r >> div_shift(op_r);
    res_nxt  = shifted[7:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      prod_r <= prod_nxt;
      op_r   <= op;
    end
    if (ctl.ld_out) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

[rtl/core/bc1_bc3_texel_block_decoder.sv]
// ----------------------------------------------------------------------------
// bc1_bc3_texel_block_decoder
// decodes one bc1 or bc3 4x4 block into sixteen rgba texels, row-major
// ----------------------------------------------------------------------------
// throughput: one texel per cycle while out_stall lets the output move; the
//   texel issue counter on the block register steps through each block's texels
// stages: block register, index select, numerators, multiply, output
// reset: synchronous active-low rst_n clears all valid bits, the texel
//   counter and format_mode (bc1); payload registers are not reset
// ----------------------------------------------------------------------------
`include "bc1_bc3_texel_block_decoder_macros.svh"

module bc1_bc3_texel_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // block input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_color_block,
  input  logic [63:0] in_alpha_block,
  // texel output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_texel_x,
  output logic [1:0]  out_texel_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_last
);
  import bc13_pkg::*;

  // register index 0 sits at byte 0, index taken from the word address bit
  localparam logic REG_FORMAT_MODE = 1'b0;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic fmt_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_FORMAT_MODE) ? {31'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_FORMAT_MODE) begin
      fmt_r <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // stage load enables, ripple back from the output register
  // --------------------------------------------------------------------------
  logic      t1_v_r, t2_v_r, t3_v_r, t4_v_r;
  logic      en1, en2, en3, en4;
  pipe_ctl_t div_ctl;

  assign en4 = !t4_v_r || !out_stall;
  assign en3 = !t3_v_r || en4;
  assign en2 = !t2_v_r || en3;
  assign en1 = !t1_v_r || en2;

  assign div_ctl.ld_mul = en3;
  assign div_ctl.ld_out = en4;

  // --------------------------------------------------------------------------
  // block register and texel issue counter
  // --------------------------------------------------------------------------
  logic        blk_v_r;
  logic [63:0] cb_r, ab_r;
  logic        bc3_r;
  logic [3:0]  cnt_r;
  logic        issue, issue_last, blk_ld;

  assign issue      = blk_v_r && en1;
  assign issue_last = issue && cnt_r == 4'hF;
  // next block is taken while the last texel of this one moves on
  assign blk_ld     = !blk_v_r || issue_last;
  assign in_stall   = !blk_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_v_r <= 1'b0;
      cnt_r   <= 4'd0;
    end else if (blk_ld) begin
      blk_v_r <= in_valid;
      cnt_r   <= 4'd0;
    end else if (issue) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  // mode is latched with the block so a texel never sees a mixed format
  always_ff @(posedge clk) begin
    if (blk_ld && in_valid) begin
      cb_r  <= in_color_block;
      ab_r  <= in_alpha_block;
      bc3_r <= fmt_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: pick this texel's indices, carry the block endpoints along
  // --------------------------------------------------------------------------
  logic [1:0]  t1_ci_r, t1_ci_nxt;
  logic [2:0]  t1_ai_r, t1_ai_nxt;
  logic [15:0] t1_c0_r, t1_c1_r;
  logic [7:0]  t1_a0_r, t1_a1_r;
  logic        t1_bc3_r, t1_four_r, t1_four_nxt;
  logic [3:0]  t1_pos_r;
  logic [31:0] cidx_sh;
  logic [47:0] aidx_sh;
  logic [5:0]  aidx_amt;

  always_comb begin
    cidx_sh     = cb_r[63:32] >> {cnt_r, 1'b0};
    aidx_amt    = {2'b00, cnt_r} + {1'b0, cnt_r, 1'b0};
    aidx_sh     = ab_r[63:16] >> aidx_amt;
    t1_ci_nxt   = cidx_sh[1:0];
    t1_ai_nxt   = aidx_sh[2:0];
    // bc3 colour is always the four-entry palette
    t1_four_nxt = bc3_r || (cb_r[15:0] > cb_r[31:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (en1) begin
      t1_v_r <= blk_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      t1_ci_r   <= t1_ci_nxt;
      t1_ai_r   <= t1_ai_nxt;
      t1_c0_r   <= cb_r[15:0];
      t1_c1_r   <= cb_r[31:16];
      t1_a0_r   <= ab_r[7:0];
      t1_a1_r   <= ab_r[15:8];
      t1_bc3_r  <= bc3_r;
      t1_four_r <= t1_four_nxt;
      t1_pos_r  <= cnt_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: widen 565 endpoints (shift only) and form weighted numerators
  // --------------------------------------------------------------------------
  function automatic logic [9:0] color_num(input logic [7:0] a, input logic [7:0] b,
                                           input logic [1:0] ci, input logic four);
    logic [9:0] n;
    case (ci)
      2'd0:    n = {2'b00, a};
      2'd1:    n = {2'b00, b};
      2'd2:    n = four ? ({1'b0, a, 1'b0} + {2'b00, b}) : ({2'b00, a} + {2'b00, b});
      2'd3:    n = four ? ({2'b00, a} + {1'b0, b, 1'b0}) : 10'd0;
      default: n = 10'd0;
    endcase
    return n;
  endfunction

  logic [7:0]       r0, g0, b0, r1, g1, b1;
  logic [2:0]       aw0, aw1;
  logic [NUM_W-1:0] a_num_nxt;
  div_op_t          c_op_nxt, a_op_nxt;

  logic [9:0]       t2_r_num_r, t2_g_num_r, t2_b_num_r;
  logic [NUM_W-1:0] t2_a_num_r;
  div_op_t          t2_c_op_r, t2_a_op_r;
  logic [3:0]       t2_pos_r;

  always_comb begin
    r0 = {t1_c0_r[15:11], 3'b000};
    g0 = {t1_c0_r[10:5], 2'b00};
    b0 = {t1_c0_r[4:0], 3'b000};
    r1 = {t1_c1_r[15:11], 3'b000};
    g1 = {t1_c1_r[10:5], 2'b00};
    b1 = {t1_c1_r[4:0], 3'b000};

    case (t1_ci_r)
      2'd2:    c_op_nxt = t1_four_r ? DIV_BY3 : DIV_BY2;
      2'd3:    c_op_nxt = t1_four_r ? DIV_BY3 : DIV_PASS;
      default: c_op_nxt = DIV_PASS;
    endcase

    aw0       = 3'd0;
    aw1       = 3'd0;
    a_num_nxt = NUM_W'(255);
    a_op_nxt  = DIV_PASS;
    if (!t1_bc3_r) begin
      // bc1: only the transparent-black entry clears alpha
      if (!t1_four_r && t1_ci_r == 2'd3) begin
        a_num_nxt = '0;
      end
    end else if (t1_ai_r == 3'd0) begin
      a_num_nxt = {3'b000, t1_a0_r};
    end else if (t1_ai_r == 3'd1) begin
      a_num_nxt = {3'b000, t1_a1_r};
    end else if (t1_a0_r > t1_a1_r) begin
      // eight-value palette
      aw0       = 3'd0 - t1_ai_r;
      aw1       = t1_ai_r - 3'd1;
      a_num_nxt = NUM_W'({3'b000, t1_a0_r} * {8'd0, aw0})
                + NUM_W'({3'b000, t1_a1_r} * {8'd0, aw1});
      a_op_nxt  = DIV_BY7;
    end else if (t1_ai_r == 3'd6) begin
      a_num_nxt = '0;
    end else if (t1_ai_r == 3'd7) begin
      a_num_nxt = NUM_W'(255);
    end else begin
      // six-value palette
      aw0       = 3'd6 - t1_ai_r;
      aw1       = t1_ai_r - 3'd1;
      a_num_nxt = NUM_W'({3'b000, t1_a0_r} * {8'd0, aw0})
                + NUM_W'({3'b000, t1_a1_r} * {8'd0, aw1});
      a_op_nxt  = DIV_BY5;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else if (en2) begin
      t2_v_r <= t1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      t2_r_num_r <= color_num(r0, r1, t1_ci_r, t1_four_r);
      t2_g_num_r <= color_num(g0, g1, t1_ci_r, t1_four_r);
      t2_b_num_r <= color_num(b0, b1, t1_ci_r, t1_four_r);
      t2_a_num_r <= a_num_nxt;
      t2_c_op_r  <= c_op_nxt;
      t2_a_op_r  <= a_op_nxt;
      t2_pos_r   <= t1_pos_r;
    end
  end

  // --------------------------------------------------------------------------
  // stages 3 and 4: reciprocal multiply and shift, one unit per channel
  // --------------------------------------------------------------------------
  logic [3:0] t3_pos_r, t4_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
    end else begin
      if (en3) begin
        t3_v_r <= t2_v_r;
      end
      if (en4) begin
        t4_v_r <= t3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      t3_pos_r <= t2_pos_r;
    end
    if (en4) begin
      t4_pos_r <= t3_pos_r;
    end
  end

  bc13_chan_div u_div_red (
    .clk    (clk),
    .ctl    (div_ctl),
    .num    ({1'b0, t2_r_num_r}),
    .op     (t2_c_op_r),
    .result (out_red)
  );

  bc13_chan_div u_div_green (
    .clk    (clk),
    .ctl    (div_ctl),
    .num    ({1'b0, t2_g_num_r}),
    .op     (t2_c_op_r),
    .result (out_green)
  );

  bc13_chan_div u_div_blue (
    .clk    (clk),
    .ctl    (div_ctl),
    .num    ({1'b0, t2_b_num_r}),
    .op     (t2_c_op_r),
    .result (out_blue)
  );

  bc13_chan_div u_div_alpha (
    .clk    (clk),
    .ctl    (div_ctl),
    .num    (t2_a_num_r),
    .op     (t2_a_op_r),
    .result (out_alpha)
  );

  assign out_valid   = t4_v_r;
  assign out_texel_x = t4_pos_r[1:0];
  assign out_texel_y = t4_pos_r[3:2];
  assign out_last    = t4_pos_r == 4'hF;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `BCD_ASSERT_IMP(a_empty_takes, !blk_v_r, !in_stall, "empty block register stalls input")
  `BCD_ASSERT_IMP(a_take_on_last, in_valid && !in_stall && blk_v_r, issue_last,
                  "block replaced before its last texel issued")
  `BCD_ASSERT_NXT(a_cnt_step, issue && cnt_r != 4'hF,
                  blk_v_r && cnt_r == $past(cnt_r) + 4'd1, "texel counter skipped")
  `BCD_ASSERT_NXT(a_hold_on_stall, !issue && blk_v_r, blk_v_r && $stable(cnt_r),
                  "texel counter moved without issue")

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bc1/bc3 texel block decoder: blocks go in over
// valid/stall, every texel coming out is compared field by field against a
// local decode of the same block under the current format setting
// ----------------------------------------------------------------------------
module tb;

  import bc13_pkg::*;

  // format register codes and addresses
  typedef enum bit {
    MODE_BC1 = 1'b0,
    MODE_BC3 = 1'b1
  } format_t;

  localparam logic [2:0] REG_FORMAT = 3'd0;  // format_mode register
  localparam logic [2:0] REG_UNUSED = 3'd4;  // no register here, writes fall through

  localparam logic [31:0] IDX_0123   = 32'he4e4e4e4;        // colour indices 0,1,2,3,...
  localparam logic [47:0] AIDX_0TO7  = 48'hfac688fac688;    // alpha indices 0..7 twice
  localparam int          STUCK_LIMIT = 2000;               // cycles with no handshake

  typedef struct packed {
    logic [1:0] x;
    logic [1:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } texel_t;

  // expected texels of accepted blocks, oldest first
  class texel_scoreboard;
    texel_t texel_q[$];
    bit     format_mode;
    int     errors;

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function int unsigned mix_color(int unsigned a, int unsigned b, int unsigned idx, bit four);
      case (idx)
        0: return a;
        1: return b;
        2: return four ? (2 * a + b) / 3 : (a + b) / 2;
        default: return four ? (a + 2 * b) / 3 : 0;
      endcase
    endfunction

    function int unsigned mix_alpha(int unsigned a0, int unsigned a1, int unsigned idx);
      if (idx == 0) return a0;
      if (idx == 1) return a1;
      if (a0 > a1) return ((8 - idx) * a0 + (idx - 1) * a1) / 7;
      if (idx == 6) return 0;
      if (idx == 7) return 255;
      return ((6 - idx) * a0 + (idx - 1) * a1) / 5;
    endfunction

    // decode one block into its sixteen texels
    function void note_block(logic [63:0] cb, logic [63:0] ab);
      logic [15:0] c0, c1;
      int unsigned r0, g0, b0, r1, g1, b1, ci, ai, alp;
      bit four;
      texel_t t;
      c0 = cb[15:0];
      c1 = cb[31:16];
      four = (format_mode == MODE_BC3) || (c0 > c1);
      r0 = {c0[15:11], 3'b000};
      g0 = {c0[10:5], 2'b00};
      b0 = {c0[4:0], 3'b000};
      r1 = {c1[15:11], 3'b000};
      g1 = {c1[10:5], 2'b00};
      b1 = {c1[4:0], 3'b000};
      for (int i = 0; i < 16; i++) begin
        ci = cb[32 + 2 * i +: 2];
        ai = ab[16 + 3 * i +: 3];
        if (format_mode == MODE_BC3) alp = mix_alpha(ab[7:0], ab[15:8], ai);
        else alp = (!four && ci == 3) ? 0 : 255;
        t.x     = 2'(i);
        t.y     = 2'(i >> 2);
        t.red   = 8'(mix_color(r0, r1, ci, four));
        t.green = 8'(mix_color(g0, g1, ci, four));
        t.blue  = 8'(mix_color(b0, b1, ci, four));
        t.alpha = 8'(alp);
        t.last  = (i == 15);
        texel_q.push_back(t);
      end
    endfunction

    task cmp(string name, int unsigned got, int unsigned want, texel_t w);
      if (got != want)
        report($sformatf("%s got %0d expected %0d at texel (%0d,%0d)",
                         name, got, want, w.x, w.y));
    endtask

    task check_texel(texel_t got);
      texel_t want;
      if (texel_q.size() == 0) begin
        report($sformatf("texel (%0d,%0d) with no block pending", got.x, got.y));
        return;
      end
      want = texel_q.pop_front();
      cmp("texel_x", got.x, want.x, want);
      cmp("texel_y", got.y, want.y, want);
      cmp("red", got.red, want.red, want);
      cmp("green", got.green, want.green, want);
      cmp("blue", got.blue, want.blue, want);
      cmp("alpha", got.alpha, want.alpha, want);
      cmp("last", got.last, want.last, want);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_color_block = '0;
  logic [63:0] in_alpha_block = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_texel_x;
  logic [1:0]  out_texel_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_last;

  texel_scoreboard sb = new();
  bit              idling = 1'b1;  // random gaps and stalls allowed
  int              stuck;          // cycles since the last handshake

  bc1_bc3_texel_block_decoder i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_color_block(in_color_block),
    .in_alpha_block(in_alpha_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_texel_x   (out_texel_x),
    .out_texel_y   (out_texel_y),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_last      (out_last)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // block items taken by the decoder are decoded locally at the same edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_block(in_color_block, in_alpha_block);
  end

  // every texel taken from the decoder is checked against the oldest expectation
  always @(posedge clk) begin : texel_mon
    texel_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x     = out_texel_x;
      got.y     = out_texel_y;
      got.red   = out_red;
      got.green = out_green;
      got.blue  = out_blue;
      got.alpha = out_alpha;
      got.last  = out_last;
      sb.check_texel(got);
    end
  end

  // watchdog: a run of cycles with no handshake at all means a hang
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable) || !rst_n)
      stuck = 0;
    else
      stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall bursts, only while idling, between clear runs
  initial begin : stall_gen
    int n;
    forever begin
      if (idling && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 15);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      n = $urandom_range(1, 20);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one apb transfer: setup then access; reads check bit 0 against the model
  task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr && addr == REG_FORMAT) sb.format_mode = data[0];
    if (!wr && prdata[0] !== sb.format_mode)
      sb.report($sformatf("format_mode read %0d expected %0d", prdata[0], sb.format_mode));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // set the format with junk in the upper bits, poke the empty address, read back
  task automatic set_format(format_t mode);
    apb_access(1'b1, REG_FORMAT, {31'($urandom), mode});
    apb_access(1'b1, REG_UNUSED, {31'($urandom), ~mode});
    apb_access(1'b0, REG_FORMAT, '0);
  endtask

  // present one block item, with an optional gap first, and hold it until taken
  task automatic send_block(logic [63:0] cb, logic [63:0] ab);
    int gap;
    gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_color_block <= cb;
    in_alpha_block <= ab;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every expected texel has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.texel_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // endpoints biased towards equal and extreme pairs
  function automatic logic [63:0] rand_color();
    logic [63:0] cb;
    cb = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: cb[31:16] = cb[15:0];
      1: cb[31:0] = {16'h0000, 16'hffff};
      2: cb[31:0] = {16'hffff, 16'h0000};
      default: ;
    endcase
    return cb;
  endfunction

  function automatic logic [63:0] rand_alpha();
    logic [63:0] ab;
    ab = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ab[15:8] = ab[7:0];
      1: ab[15:0] = {8'h00, 8'hff};
      2: ab[15:0] = {8'hff, 8'h00};
      default: ;
    endcase
    return ab;
  endfunction

  initial begin : main
    format_t mode;
    // reset held at the start, released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset value of the format register should read back as bc1
    apb_access(1'b0, REG_FORMAT, '0);

    // bc1 directed: equal endpoints, extremes, four and three colour palettes,
    // transparent black, alpha word carrying junk that must be ignored
    send_block({IDX_0123, 16'h0000, 16'h0000}, {$urandom, $urandom});
    send_block({IDX_0123, 16'h0000, 16'hffff}, {$urandom, $urandom});
    send_block({IDX_0123, 16'hffff, 16'h0000}, {$urandom, $urandom});
    send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_block({IDX_0123, 16'h07e0, 16'hf800}, 64'h0);
    send_block({IDX_0123, 16'hf81f, 16'h001f}, {$urandom, $urandom});
    send_block({32'h1b1b1b1b, 16'h8410, 16'h8410}, {$urandom, $urandom});
    wait_drained();

    // bc3 directed: colour always four-entry, both alpha palettes on every index
    set_format(MODE_BC3);
    send_block({IDX_0123, 16'h0000, 16'hffff}, {AIDX_0TO7, 8'h00, 8'hff});
    send_block({IDX_0123, 16'hffff, 16'h0000}, {AIDX_0TO7, 8'hff, 8'h00});
    send_block({IDX_0123, 16'h1234, 16'h1234}, {AIDX_0TO7, 8'h80, 8'h80});
    send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_block(64'h0, 64'h0);
    send_block({IDX_0123, 16'hf800, 16'h07e0}, {AIDX_0TO7, 8'h00, 8'h01});
    send_block({IDX_0123, 16'h001f, 16'hf81f}, {AIDX_0TO7, 8'hff, 8'hfe});
    send_block({IDX_0123, 16'h0000, 16'hffff}, {AIDX_0TO7, 8'h01, 8'hff});
    wait_drained();

    // random phases, alternating format; phase 2 runs without idling and the
    // last phase has none at all
    for (int p = 0; p < 7; p++) begin
      mode = format_t'(p % 2);
      idling = (p != 2 && p != 6);
      set_format(mode);
      for (int k = 0; k < 28; k++) begin
        // sender holds off once until the decoder has fully drained
        if (p == 3 && k == 14) wait_drained();
        send_block(rand_color(), rand_alpha());
      end
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (sb.texel_q.size() != 0)
      sb.report($sformatf("%0d texels never came out", sb.texel_q.size()));
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
